// ----- sv/tfht_pkg.sv -----
`timescale 1ns / 1ps
package tfht_pkg;

    localparam int HOME_ENTRIES     = 2048;
    localparam int OVERFLOW_ENTRIES = 1024;
    localparam int TOTAL_ENTRIES    = HOME_ENTRIES + OVERFLOW_ENTRIES;

    localparam int GUEST_W = 32;
    localparam int HOST_W  = 64;
    localparam int HOME_W  = $clog2(HOME_ENTRIES);
    localparam int POS_W   = $clog2(TOTAL_ENTRIES);
    // link 0 ends the chain, k names overflow slot k-1
    localparam int LINK_W  = $clog2(OVERFLOW_ENTRIES + 1);

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef struct packed {
        logic [GUEST_W-1:0] guest;
        logic [HOST_W-1:0]  host;
        logic [LINK_W-1:0]  link;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              re;
        logic [POS_W-1:0]  raddr;
        logic              we;
        logic [POS_W-1:0]  waddr;
        entry_t            wdata;
    } ent_req_t;

    typedef struct packed {
        logic              re;
        logic [HOME_W-1:0] raddr;
        logic              we;
        logic [HOME_W-1:0] waddr;
        logic              wdata;
    } home_req_t;

endpackage

// ----- sv/tfht_ram.sv -----
`timescale 1ns / 1ps
module tfht_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tfht_ctrl.sv -----
`timescale 1ns / 1ps
module tfht_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [tfht_pkg::GUEST_W-1:0] s_guest_addr,
    input  logic [tfht_pkg::HOST_W-1:0]  s_host_addr,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_found,
    output logic [tfht_pkg::HOST_W-1:0]  m_result_addr,
    output logic                         m_table_full,
    output tfht_pkg::ent_req_t           ent_req,
    input  tfht_pkg::entry_t             ent_rdata,
    output tfht_pkg::home_req_t          home_req,
    input  logic                         home_rdata
);
    import tfht_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_HOME  = 7'b0000100,
        ST_WALK  = 7'b0001000,
        ST_LINK  = 7'b0010000,
        ST_FRESH = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [HOME_W-1:0]   clr_reg, clr_next;
    logic [LINK_W-1:0]   nfo_reg, nfo_next;
    logic                mode_reg, mode_next;
    logic [GUEST_W-1:0]  guest_reg, guest_next;
    logic [HOST_W-1:0]   host_reg, host_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                res_found_reg, res_found_next;
    logic [HOST_W-1:0]   res_addr_reg, res_addr_next;
    logic                res_full_reg, res_full_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_found_reg, m_found_next;
    logic [HOST_W-1:0]   m_addr_reg, m_addr_next;
    logic                m_full_reg, m_full_next;

    logic                live;
    logic [POS_W-1:0]    link_pos;
    logic [HOME_W-1:0]   s_bucket;

    assign s_bucket = s_guest_addr[HOME_W+1:2];
    assign live     = (state_reg == ST_HOME) ? home_rdata : 1'b1;
    assign link_pos = POS_W'(HOME_ENTRIES) + POS_W'(ent_rdata.link) - POS_W'(1);

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_result_addr = m_addr_reg;
    assign m_table_full  = m_full_reg;

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        nfo_next       = nfo_reg;
        mode_next      = mode_reg;
        guest_next     = guest_reg;
        host_next      = host_reg;
        pos_next       = pos_reg;
        res_found_next = res_found_reg;
        res_addr_next  = res_addr_reg;
        res_full_next  = res_full_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        m_found_next   = m_found_reg;
        m_addr_next    = m_addr_reg;
        m_full_next    = m_full_reg;
        ent_req        = '0;
        home_req       = '0;

        case (state_reg)
            ST_CLEAR: begin
                home_req.we    = 1'b1;
                home_req.waddr = clr_reg;
                home_req.wdata = 1'b0;
                clr_next       = clr_reg + HOME_W'(1);
                if (clr_reg == {HOME_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next      = s_mode;
                    guest_next     = s_guest_addr;
                    host_next      = s_host_addr;
                    pos_next       = POS_W'(s_bucket);
                    res_found_next = 1'b0;
                    res_addr_next  = '0;
                    res_full_next  = 1'b0;
                    home_req.re    = 1'b1;
                    home_req.raddr = s_bucket;
                    ent_req.re     = 1'b1;
                    ent_req.raddr  = POS_W'(s_bucket);
                    state_next     = ST_HOME;
                end
            end
            ST_HOME, ST_WALK: begin
                if (!live) begin
                    // empty home slot: lookup misses, insert claims it
                    if (mode_reg == MODE_INSERT) begin
                        home_req.we         = 1'b1;
                        home_req.waddr      = pos_reg[HOME_W-1:0];
                        home_req.wdata      = 1'b1;
                        ent_req.we          = 1'b1;
                        ent_req.waddr       = pos_reg;
                        ent_req.wdata.guest = guest_reg;
                        ent_req.wdata.host  = host_reg;
                        ent_req.wdata.link  = '0;
                    end
                    state_next = ST_DONE;
                end else if (mode_reg == MODE_LOOKUP) begin
                    if (ent_rdata.guest == guest_reg) begin
                        res_found_next = 1'b1;
                        res_addr_next  = ent_rdata.host;
                        state_next     = ST_DONE;
                    end else if (ent_rdata.link == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        ent_req.re    = 1'b1;
                        ent_req.raddr = link_pos;
                        pos_next      = link_pos;
                        state_next    = ST_WALK;
                    end
                end else if ((state_reg == ST_HOME) &&
                             (nfo_reg == LINK_W'(OVERFLOW_ENTRIES))) begin
                    res_full_next = 1'b1;
                    state_next    = ST_DONE;
                end else if (ent_rdata.link == '0) begin
                    state_next = ST_LINK;
                end else begin
                    ent_req.re    = 1'b1;
                    ent_req.raddr = link_pos;
                    pos_next      = link_pos;
                    state_next    = ST_WALK;
                end
            end
            ST_LINK: begin
                // rewrite the tail with a link to the fresh overflow slot
                ent_req.we         = 1'b1;
                ent_req.waddr      = pos_reg;
                ent_req.wdata      = ent_rdata;
                ent_req.wdata.link = nfo_reg + LINK_W'(1);
                state_next         = ST_FRESH;
            end
            ST_FRESH: begin
                ent_req.we          = 1'b1;
                ent_req.waddr       = POS_W'(HOME_ENTRIES) + POS_W'(nfo_reg);
                ent_req.wdata.guest = guest_reg;
                ent_req.wdata.host  = host_reg;
                ent_req.wdata.link  = '0;
                nfo_next            = nfo_reg + LINK_W'(1);
                state_next          = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_addr_next  = res_addr_reg;
                    m_full_next  = res_full_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            nfo_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            nfo_reg     <= nfo_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        guest_reg     <= guest_next;
        host_reg      <= host_next;
        pos_reg       <= pos_next;
        res_found_reg <= res_found_next;
        res_addr_reg  <= res_addr_next;
        res_full_reg  <= res_full_next;
        m_found_reg   <= m_found_next;
        m_addr_reg    <= m_addr_next;
        m_full_reg    <= m_full_next;
    end

endmodule

// ----- sv/translation_fragment_hash_table.sv -----
`timescale 1ns / 1ps
// Guest-to-host code address table, hashed on guest_addr[12:2] with chained
// overflow slots.
// Input channel s_*: s_mode selects lookup or insert, s_guest_addr is the
// key, s_host_addr is stored on insert. Output channel m_*: one beat per
// input beat, in order: m_found / m_result_addr for lookups, m_table_full
// when an insert finds the overflow area used up (that insert is dropped).
// Items are handled one at a time by a small sequencer around one entry
// RAM port; s_ready is high only while it is idle.
// A hit or miss at the home slot steps through the HOME and DONE states,
// with one WALK step added per overflow link followed. An insert into
// an occupied bucket walks to the chain tail and then writes the tail
// link (LINK) and the fresh overflow slot (FRESH). The next item is taken
// in the cycle after the result is registered, not before.
// A result waiting on a stalled m_ready stays in the output register while
// the next item is accepted and worked; the block holds its next result
// until the output register frees up.
// After reset the home valid bits are cleared one per cycle: s_ready stays
// low until all 2048 of them are cleared.
module translation_fragment_hash_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [tfht_pkg::GUEST_W-1:0] s_guest_addr,
    input  logic [tfht_pkg::HOST_W-1:0]  s_host_addr,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_found,
    output logic [tfht_pkg::HOST_W-1:0]  m_result_addr,
    output logic                         m_table_full
);
    import tfht_pkg::*;

    ent_req_t   ent_req;
    home_req_t  home_req;
    entry_t     ent_rdata;
    logic       home_rdata;

    tfht_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_guest_addr  (s_guest_addr),
        .s_host_addr   (s_host_addr),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_result_addr (m_result_addr),
        .m_table_full  (m_table_full),
        .ent_req       (ent_req),
        .ent_rdata     (ent_rdata),
        .home_req      (home_req),
        .home_rdata    (home_rdata)
    );

    tfht_ram #(
        .DEPTH (TOTAL_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ent_req.we),
        .waddr (ent_req.waddr),
        .wdata (ent_req.wdata),
        .re    (ent_req.re),
        .raddr (ent_req.raddr),
        .rdata (ent_rdata)
    );

    tfht_ram #(
        .DEPTH (HOME_ENTRIES),
        .WIDTH (1)
    ) u_home_ram (
        .aclk  (aclk),
        .we    (home_req.we),
        .waddr (home_req.waddr),
        .wdata (home_req.wdata),
        .re    (home_req.re),
        .raddr (home_req.raddr),
        .rdata (home_rdata)
    );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import tfht_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int BUSY_BUCKETS   = 24;
    localparam int SETTLE_CYCLES  = 200;

    typedef struct packed {
        logic              found;
        logic [HOST_W-1:0] addr;
        logic              full;
    } table_reply_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_mode = MODE_LOOKUP;
    logic [GUEST_W-1:0]  s_guest_addr = '0;
    logic [HOST_W-1:0]   s_host_addr = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_found;
    logic [HOST_W-1:0]   m_result_addr;
    logic                m_table_full;

    // shadow copy of the table contents
    logic                home_used   [HOME_ENTRIES];
    logic [GUEST_W-1:0]  slot_guest  [TOTAL_ENTRIES];
    logic [HOST_W-1:0]   slot_host   [TOTAL_ENTRIES];
    logic [LINK_W-1:0]   slot_link   [TOTAL_ENTRIES];
    int                  overflow_used = 0;

    table_reply_t        pending_replies [$];
    logic [GUEST_W-1:0]  known_guests [$];
    logic [HOME_W-1:0]   busy_buckets [BUSY_BUCKETS];
    logic                idle_on = 1'b1;
    int                  ready_hold = 0;
    int                  fail_count = 0;

    translation_fragment_hash_table u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_guest_addr  (s_guest_addr),
        .s_host_addr   (s_host_addr),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_result_addr (m_result_addr),
        .m_table_full  (m_table_full)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic table_reply_t predict_reply(input logic mode,
                                                   input logic [GUEST_W-1:0] guest,
                                                   input logic [HOST_W-1:0] host);
        table_reply_t r;
        int unsigned  home;
        int unsigned  pos;
        int unsigned  fresh;
        int           steps;
        logic         done;
        r = '0;
        home = (guest >> 2) % HOME_ENTRIES;
        if (mode == MODE_LOOKUP) begin
            if (home_used[home]) begin
                pos = home;
                done = 1'b0;
                for (steps = 0; !done && steps <= OVERFLOW_ENTRIES; steps++) begin
                    if (slot_guest[pos] == guest) begin
                        r.found = 1'b1;
                        r.addr  = slot_host[pos];
                        done = 1'b1;
                    end else if (slot_link[pos] == 0 || slot_link[pos] > OVERFLOW_ENTRIES) begin
                        done = 1'b1;
                    end else begin
                        pos = HOME_ENTRIES + slot_link[pos] - 1;
                    end
                end
            end
        end else if (!home_used[home]) begin
            home_used[home]  = 1'b1;
            slot_guest[home] = guest;
            slot_host[home]  = host;
            slot_link[home]  = '0;
        end else if (overflow_used >= OVERFLOW_ENTRIES) begin
            r.full = 1'b1;
        end else begin
            fresh = HOME_ENTRIES + overflow_used;
            slot_guest[fresh] = guest;
            slot_host[fresh]  = host;
            slot_link[fresh]  = '0;
            // append at the tail of the chain
            pos = home;
            done = 1'b0;
            for (steps = 0; !done && steps <= OVERFLOW_ENTRIES; steps++) begin
                if (slot_link[pos] == 0 || slot_link[pos] > OVERFLOW_ENTRIES ||
                    HOME_ENTRIES + slot_link[pos] - 1 == fresh)
                    done = 1'b1;
                else
                    pos = HOME_ENTRIES + slot_link[pos] - 1;
            end
            slot_link[pos] = LINK_W'(overflow_used + 1);
            overflow_used++;
        end
        return r;
    endfunction

    function automatic logic [GUEST_W-1:0] pick_guest();
        logic [GUEST_W-1:0] g;
        g = $urandom;
        if ($urandom_range(0, 9) != 0)
            g[HOME_W+1:2] = busy_buckets[$urandom_range(0, BUSY_BUCKETS-1)];
        return g;
    endfunction

    function automatic logic [HOST_W-1:0] pick_host();
        logic [HOST_W-1:0] h;
        h = {$urandom, $urandom};
        case ($urandom_range(0, 31))
            0: h = '0;
            1: h = '1;
            default: ;
        endcase
        return h;
    endfunction

    task automatic send_request(input logic mode, input logic [GUEST_W-1:0] guest,
                                input logic [HOST_W-1:0] host);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_guest_addr <= guest;
        s_host_addr  <= host;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_replies.push_back(predict_reply(mode, guest, host));
        if (mode == MODE_INSERT)
            known_guests.push_back(guest);
    endtask

    task automatic random_request(input int insert_pct);
        logic               mode;
        logic [GUEST_W-1:0] guest;
        mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_LOOKUP;
        // lookups mostly hit stored keys; inserts now and then repeat one
        if (known_guests.size() != 0 &&
            $urandom_range(0, 9) < ((mode == MODE_INSERT) ? 1 : 6))
            guest = known_guests[$urandom_range(0, known_guests.size() - 1)];
        else
            guest = pick_guest();
        send_request(mode, guest, pick_host());
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        // empty table: home slot not yet valid
        send_request(MODE_LOOKUP, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        // zero host address is a real stored value
        send_request(MODE_INSERT, 32'h0000_0000, 64'h0);
        send_request(MODE_LOOKUP, 32'h0000_0000, 64'h0000_0000_0000_1234);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 64'h0);
        // chain on bucket 0
        send_request(MODE_INSERT, 32'h0000_2000, 64'h0123_4567_89AB_CDEF);
        send_request(MODE_INSERT, 32'h8000_0001, 64'h8000_0000_0000_0000);
        send_request(MODE_INSERT, 32'hFFFF_E003, 64'h0000_0000_0000_0001);
        send_request(MODE_LOOKUP, 32'hFFFF_E003, 64'hAAAA_5555_AAAA_5555);
        send_request(MODE_LOOKUP, 32'h8000_0001, 64'h0);
        send_request(MODE_LOOKUP, 32'h0000_2000, 64'h0);
        // duplicate key: the earlier entry still answers
        send_request(MODE_INSERT, 32'h0000_2000, 64'hDEAD_BEEF_0000_0000);
        send_request(MODE_LOOKUP, 32'h0000_2000, 64'h0);
        // misses after walking the whole chain
        send_request(MODE_LOOKUP, 32'h0000_4000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(MODE_LOOKUP, 32'h0000_0002, 64'h0);
        // collision on the top bucket
        send_request(MODE_INSERT, 32'h7FFF_FFFC, 64'h5555_AAAA_5555_AAAA);
        send_request(MODE_LOOKUP, 32'h7FFF_FFFC, 64'h0);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 64'h0);
        send_request(MODE_LOOKUP, 32'h0000_0000, 64'h0);
        wait_drained();
    endtask

    task automatic test_chain_fill();
        int n;
        for (n = 0; n < BUSY_BUCKETS; n++)
            busy_buckets[n] = HOME_W'($urandom);
        n = 0;
        while (overflow_used < OVERFLOW_ENTRIES && n < 1600) begin
            random_request(92);
            n++;
        end
        wait_drained();
    endtask

    task automatic test_table_full();
        repeat (100) random_request(50);
        wait_drained();
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        repeat (80) random_request(30);
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_hold <= $urandom_range(0, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_reply
        table_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected beat: found=%0b addr=%h full=%0b",
                             m_found, m_result_addr, m_table_full);
            end else begin
                want = pending_replies.pop_front();
                if (m_found !== want.found || m_result_addr !== want.addr ||
                    m_table_full !== want.full) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: exp found=%0b addr=%h full=%0b, got found=%0b addr=%h full=%0b",
                                 want.found, want.addr, want.full,
                                 m_found, m_result_addr, m_table_full);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : run_tests
        int i;
        for (i = 0; i < HOME_ENTRIES; i++)
            home_used[i] = 1'b0;
        for (i = 0; i < TOTAL_ENTRIES; i++) begin
            slot_guest[i] = '0;
            slot_host[i]  = '0;
            slot_link[i]  = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_chain_fill();
        test_table_full();
        test_steady_stream();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/tfht_pkg.sv
sv/tfht_ram.sv
sv/tfht_ctrl.sv
sv/translation_fragment_hash_table.sv
sim/testbench.sv
